[design/sdspi_pkg.sv]
// Shared types, constants and the CRC7 byte step for the SD SPI command block.
// No dependencies; every other file imports this package.
package sdspi_pkg;

  // Input opcodes
  typedef enum logic {
    OP_START = 1'b0,
    OP_RX    = 1'b1
  } op_t;

  // Result kinds
  localparam logic KIND_TX = 1'b0;
  localparam logic KIND_RX = 1'b1;

  // Command progress
  typedef enum logic [1:0] {
    PH_IDLE    = 2'd0,
    PH_WAIT_R1 = 2'd1,
    PH_EXTRA   = 2'd2
  } phase_t;

  // Work passed from the front to the back
  typedef enum logic [1:0] {
    JOB_FAULT = 2'd0,
    JOB_FRAME = 2'd1,
    JOB_RESP  = 2'd2
  } job_kind_t;

  typedef struct packed {
    job_kind_t   kind;
    logic [5:0]  cmd;
    logic [31:0] arg;
    logic [7:0]  data;
    logic [2:0]  pos;
    logic        last;
  } job_t;

  localparam logic [2:0] MAX_RESPONSE_BYTES = 3'd5;
  localparam logic [2:0] FRAME_LAST         = 3'd5;
  localparam logic [7:0] CMD_START_BITS     = 8'h40;
  localparam logic [7:0] FILL_BYTE          = 8'hFF;
  localparam logic [6:0] CRC7_POLY          = 7'h09;

  // Queue sizing
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Advance CRC7 (x^7+x^3+1) over one byte, MSB first
  function automatic logic [6:0] crc7_byte(input logic [6:0] crc_in, input logic [7:0] d);
    logic [6:0] acc;
    logic       top;
    acc = crc_in;
    for (int b = 7; b >= 0; b--) begin
      top = d[b] ^ acc[6];
      acc = {acc[5:0], 1'b0};
      if (top) begin
        acc = acc ^ CRC7_POLY;
      end
    end
    return acc;
  endfunction

endpackage

[design/sdspi_front.sv]
// Front end: accepts input requests, tracks the command phase and queues work.
// Depends on sdspi_pkg.
module sdspi_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              in_opcode,
  input  logic [5:0]        in_command_index,
  input  logic [31:0]       in_argument,
  input  logic [2:0]        in_response_length,
  input  logic [7:0]        in_rx_byte,
  input  logic              q_full,
  output logic              q_push,
  output sdspi_pkg::job_t   q_job
);
  import sdspi_pkg::*;

  phase_t     phase_r, phase_nxt;
  logic [2:0] rem_r, rem_nxt;
  logic [2:0] pos_r, pos_nxt;
  logic       busy;
  logic       accept;
  logic [2:0] rlen;

  // Accept whenever the queue has room
  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  // Clamp the response length to 1..MAX_RESPONSE_BYTES
  always_comb begin
    if (in_response_length == 3'd0) begin
      rlen = 3'd1;
    end else if (in_response_length > MAX_RESPONSE_BYTES) begin
      rlen = MAX_RESPONSE_BYTES;
    end else begin
      rlen = in_response_length;
    end
  end

  // Classify the request, update phase and build the queued job
  always_comb begin
    phase_nxt = phase_r;
    rem_nxt   = rem_r;
    pos_nxt   = pos_r;
    q_push    = 1'b0;
    q_job     = '0;
    busy      = (phase_r == PH_WAIT_R1) || (phase_r == PH_EXTRA);
    if (accept) begin
      case (op_t'(in_opcode))
        OP_START: begin
          q_push = 1'b1;
          if (busy) begin
            q_job.kind = JOB_FAULT;
          end else begin
            q_job.kind = JOB_FRAME;
            q_job.cmd  = in_command_index;
            q_job.arg  = in_argument;
            phase_nxt  = PH_WAIT_R1;
            rem_nxt    = rlen;
            pos_nxt    = 3'd0;
          end
        end
        OP_RX: begin
          if (!busy) begin
            q_push     = 1'b1;
            q_job.kind = JOB_FAULT;
          end else if (!(phase_r == PH_WAIT_R1 && in_rx_byte == FILL_BYTE)) begin
            q_push     = 1'b1;
            q_job.kind = JOB_RESP;
            q_job.data = in_rx_byte;
            q_job.pos  = pos_r;
            q_job.last = (rem_r <= 3'd1);
            if (rem_r <= 3'd1) begin
              phase_nxt = PH_IDLE;
              rem_nxt   = 3'd0;
              pos_nxt   = 3'd0;
            end else begin
              phase_nxt = PH_EXTRA;
              rem_nxt   = rem_r - 3'd1;
              pos_nxt   = pos_r + 3'd1;
            end
          end
        end
        default: begin
          q_push = 1'b0;
        end
      endcase
    end
  end

  // Hold phase state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      rem_r   <= 3'd0;
      pos_r   <= 3'd0;
    end else begin
      phase_r <= phase_nxt;
      rem_r   <= rem_nxt;
      pos_r   <= pos_nxt;
    end
  end

  a_idle_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_IDLE) |-> (rem_r == 3'd0 && pos_r == 3'd0))
    else $error("idle phase with response counters set");

  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_full)
    else $error("job pushed into a full queue");

endmodule

[design/sdspi_queue.sv]
// Short job queue between the front and back ends, first-word-fall-through.
// Depends on sdspi_pkg.
module sdspi_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  sdspi_pkg::job_t   push_job,
  input  logic              pop,
  output sdspi_pkg::job_t   head,
  output logic              full,
  output logic              empty
);
  import sdspi_pkg::*;

  job_t              mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] count_r, count_nxt;
  logic              do_push;
  logic              do_pop;

  assign full    = (count_r == QCNT_W'(QUEUE_DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = mem[rd_ptr_r];

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + QPTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + QPTR_W'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + QCNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Store pushed jobs
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= push_job;
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= QCNT_W'(QUEUE_DEPTH))
    else $error("queue occupancy beyond depth");

endmodule

[design/sdspi_back.sv]
// Back end: drains queued jobs into the result register, one byte per cycle while
// out_ready allows, framing commands and running CRC7 as the frame goes out. Depends on sdspi_pkg.
module sdspi_back (
  input  logic              clk,
  input  logic              rst_n,
  input  sdspi_pkg::job_t   q_head,
  input  logic              q_empty,
  output logic              q_pop,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              out_kind,
  output logic [7:0]        out_byte_value,
  output logic [2:0]        out_byte_position,
  output logic              out_last,
  output logic              out_fault
);
  import sdspi_pkg::*;

  logic [2:0] cnt_r, cnt_nxt;
  logic [6:0] crc_r, crc_nxt;
  logic [6:0] crc_in;
  logic [7:0] frame_byte;
  logic       load;

  logic       out_valid_r;
  logic       out_kind_r, kind_nxt;
  logic [7:0] out_byte_value_r, value_nxt;
  logic [2:0] out_byte_position_r, position_nxt;
  logic       out_last_r, last_nxt;
  logic       out_fault_r, fault_nxt;

  // Load the result register when a job is queued and the register is empty or being drained
  assign load = !q_empty && (!out_valid_r || out_ready);

  // Select the frame byte for the current position
  always_comb begin
    case (cnt_r)
      3'd0:    frame_byte = CMD_START_BITS | {2'b00, q_head.cmd};
      3'd1:    frame_byte = q_head.arg[31:24];
      3'd2:    frame_byte = q_head.arg[23:16];
      3'd3:    frame_byte = q_head.arg[15:8];
      3'd4:    frame_byte = q_head.arg[7:0];
      3'd5:    frame_byte = {crc_r, 1'b1};
      default: frame_byte = '0;
    endcase
  end

  // Build the next result and advance the frame counter
  always_comb begin
    crc_in       = (cnt_r == 3'd0) ? 7'd0 : crc_r;
    cnt_nxt      = cnt_r;
    crc_nxt      = crc_r;
    q_pop        = 1'b0;
    kind_nxt     = KIND_TX;
    value_nxt    = '0;
    position_nxt = '0;
    last_nxt     = 1'b0;
    fault_nxt    = 1'b0;
    case (q_head.kind)
      JOB_FRAME: begin
        value_nxt    = frame_byte;
        position_nxt = cnt_r;
        last_nxt     = (cnt_r == FRAME_LAST);
        if (load) begin
          crc_nxt = crc7_byte(crc_in, frame_byte);
          if (cnt_r == FRAME_LAST) begin
            cnt_nxt = 3'd0;
            q_pop   = 1'b1;
          end else begin
            cnt_nxt = cnt_r + 3'd1;
          end
        end
      end
      JOB_RESP: begin
        kind_nxt     = KIND_RX;
        value_nxt    = q_head.data;
        position_nxt = q_head.pos;
        last_nxt     = q_head.last;
        q_pop        = load;
      end
      default: begin
        fault_nxt = 1'b1;
        q_pop     = load;
      end
    endcase
  end

  // Hold control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      cnt_r       <= 3'd0;
      crc_r       <= 7'd0;
    end else begin
      cnt_r <= cnt_nxt;
      crc_r <= crc_nxt;
      if (load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Capture the result payload
  always_ff @(posedge clk) begin
    if (load) begin
      out_kind_r          <= kind_nxt;
      out_byte_value_r    <= value_nxt;
      out_byte_position_r <= position_nxt;
      out_last_r          <= last_nxt;
      out_fault_r         <= fault_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_kind          = out_kind_r;
  assign out_byte_value    = out_byte_value_r;
  assign out_byte_position = out_byte_position_r;
  assign out_last          = out_last_r;
  assign out_fault         = out_fault_r;

  a_frame_head: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r != 3'd0) |-> (!q_empty && q_head.kind == JOB_FRAME))
    else $error("frame in progress without a frame job at the queue head");

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= FRAME_LAST)
    else $error("frame counter past the CRC byte");

  a_fault_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_fault_r) |->
      (out_byte_value_r == 8'd0 && !out_last_r && out_kind_r == KIND_TX))
    else $error("fault result carries payload");

endmodule

[design/sd_spi_command_transaction.sv]
// Top level of the SD SPI-mode command exchange, host side.
// Depends on sdspi_pkg, sdspi_front, sdspi_queue and sdspi_back.
//
// Usage:
//   Input channel (in_*): opcode 0 starts a command (index, argument, expected
//   response length 1..5); opcode 1 delivers one byte read from the card.
//   Result channel (out_*): a start gives six transmit bytes (kind 0): 0x40|index,
//   the argument MSB first and (CRC7 << 1) | 1, the sixth marked last. Card
//   bytes give response bytes (kind 1) once R1 arrives; 0xFF fill bytes before
//   R1 give nothing. There is no timeout. A request in the wrong phase gives
//   one fault result and leaves the state unchanged.
// Timing:
//   The first result of a request passes through the job queue and then the
//   result register before it appears on out_valid. The front takes one request
//   per cycle while the 4-entry job queue has room; the back emits one result per
//   cycle while out_ready is high, an accepted start giving six and any other request at most one.
// Reset and stall:
//   Synchronous active-low reset returns the block to idle with the queue and
//   result register empty. When out_ready is low a valid result in the register holds;
//   requests keep being accepted until the queue fills, then in_ready drops.
module sd_spi_command_transaction (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_opcode,
  input  logic [5:0]  in_command_index,
  input  logic [31:0] in_argument,
  input  logic [2:0]  in_response_length,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_kind,
  output logic [7:0]  out_byte_value,
  output logic [2:0]  out_byte_position,
  output logic        out_last,
  output logic        out_fault
);
  import sdspi_pkg::*;

  job_t push_job;
  job_t head_job;
  logic q_push;
  logic q_pop;
  logic q_full;
  logic q_empty;

  // Classify requests
  sdspi_front u_front (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_opcode          (in_opcode),
    .in_command_index   (in_command_index),
    .in_argument        (in_argument),
    .in_response_length (in_response_length),
    .in_rx_byte         (in_rx_byte),
    .q_full             (q_full),
    .q_push             (q_push),
    .q_job              (push_job)
  );

  // Decouple front and back
  sdspi_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_job (push_job),
    .pop      (q_pop),
    .head     (head_job),
    .full     (q_full),
    .empty    (q_empty)
  );

  // Emit result bytes
  sdspi_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .q_head            (head_job),
    .q_empty           (q_empty),
    .q_pop             (q_pop),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_kind          (out_kind),
    .out_byte_value    (out_byte_value),
    .out_byte_position (out_byte_position),
    .out_last          (out_last),
    .out_fault         (out_fault)
  );

endmodule

[verif/sd_spi_exchange_checker.sv]
// Result checker for the SD SPI command exchange: predicts frame, response and fault bytes.
// Watches both channels of the block; depends on sdspi_pkg for opcodes, phases and constants.
`timescale 1ns / 100ps

module sd_spi_exchange_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic        in_opcode,
  input  logic [5:0]  in_command_index,
  input  logic [31:0] in_argument,
  input  logic [2:0]  in_response_length,
  input  logic [7:0]  in_rx_byte,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic        out_kind,
  input  logic [7:0]  out_byte_value,
  input  logic [2:0]  out_byte_position,
  input  logic        out_last,
  input  logic        out_fault,
  output int          error_count,
  output int          pending
);
  import sdspi_pkg::*;

  typedef struct packed {
    logic       kind;
    logic [7:0] value;
    logic [2:0] pos;
    logic       last;
    logic       fault;
  } sd_byte_t;

  // Predicted command progress
  phase_t     cmd_phase;
  logic [2:0] bytes_left;
  logic [2:0] resp_pos;

  // Bytes the block still owes, oldest first
  sd_byte_t   expected_bytes[$];

  initial begin
    error_count = 0;
    pending     = 0;
  end

  // CRC7 over the five command bytes, one bit at a time from the top
  function automatic logic [6:0] frame_crc7(input logic [39:0] head);
    logic [6:0] crc;
    logic       feedback;
    crc = '0;
    for (int i = 39; i >= 0; i--) begin
      feedback = head[i] ^ crc[6];
      crc = {crc[5:0], 1'b0};
      if (feedback) begin
        crc = crc ^ CRC7_POLY;
      end
    end
    return crc;
  endfunction

  task automatic push_fault();
    expected_bytes.push_back('{kind: KIND_TX, value: 8'h00, pos: 3'd0, last: 1'b0,
                               fault: 1'b1});
  endtask

  // Work out the bytes one accepted request causes and advance the state
  task automatic predict_request(input op_t op, input logic [5:0] cmd,
                                 input logic [31:0] arg, input logic [2:0] rlen,
                                 input logic [7:0] rx);
    logic        busy;
    logic [39:0] head;
    logic [2:0]  want_len;
    logic        final_byte;
    busy = (cmd_phase == PH_WAIT_R1) || (cmd_phase == PH_EXTRA);
    if (op == OP_START) begin
      if (busy) begin
        push_fault();
      end else begin
        head = {CMD_START_BITS | {2'b00, cmd}, arg};
        for (int k = 0; k < 5; k++) begin
          expected_bytes.push_back('{kind: KIND_TX, value: head[39 - 8 * k -: 8],
                                     pos: 3'(k), last: 1'b0, fault: 1'b0});
        end
        expected_bytes.push_back('{kind: KIND_TX, value: {frame_crc7(head), 1'b1},
                                   pos: FRAME_LAST, last: 1'b1, fault: 1'b0});
        // Zero counts as one, anything too long is cut
        want_len = rlen;
        if (want_len == 3'd0) begin
          want_len = 3'd1;
        end
        if (want_len > MAX_RESPONSE_BYTES) begin
          want_len = MAX_RESPONSE_BYTES;
        end
        cmd_phase  = PH_WAIT_R1;
        bytes_left = want_len;
        resp_pos   = 3'd0;
      end
    end else if (!busy) begin
      push_fault();
    end else if (!(cmd_phase == PH_WAIT_R1 && rx == FILL_BYTE)) begin
      final_byte = (bytes_left <= 3'd1);
      expected_bytes.push_back('{kind: KIND_RX, value: rx, pos: resp_pos,
                                 last: final_byte, fault: 1'b0});
      if (final_byte) begin
        cmd_phase  = PH_IDLE;
        bytes_left = 3'd0;
        resp_pos   = 3'd0;
      end else begin
        cmd_phase  = PH_EXTRA;
        bytes_left = bytes_left - 3'd1;
        resp_pos   = resp_pos + 3'd1;
      end
    end
  endtask

  task automatic compare_field(input string name, input logic [7:0] want,
                               input logic [7:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch: expected %0h, got %0h", $time, name, want, got);
      error_count++;
    end
  endtask

  // Match one delivered byte against the oldest prediction
  task automatic check_result();
    sd_byte_t want;
    if (expected_bytes.size() == 0) begin
      $display("%0t: unexpected result: expected none, got kind=%0d value=%02h",
               $time, out_kind, out_byte_value);
      $display("  pos=%0d last=%0d fault=%0d", out_byte_position, out_last, out_fault);
      error_count++;
    end else begin
      want = expected_bytes.pop_front();
      compare_field("kind", want.kind, out_kind);
      compare_field("byte_value", want.value, out_byte_value);
      compare_field("byte_position", want.pos, out_byte_position);
      compare_field("last", want.last, out_last);
      compare_field("fault", want.fault, out_fault);
    end
  endtask

  // Check outgoing bytes before predicting, so a request never matches its own edge
  always @(posedge clk) begin
    if (!rst_n) begin
      cmd_phase  = PH_IDLE;
      bytes_left = 3'd0;
      resp_pos   = 3'd0;
      expected_bytes.delete();
    end else begin
      if (out_valid && out_ready) begin
        check_result();
      end
      if (in_valid && in_ready) begin
        predict_request(op_t'(in_opcode), in_command_index, in_argument,
                        in_response_length, in_rx_byte);
      end
    end
    pending <= expected_bytes.size();
  end

endmodule

[verif/tb_sd_spi_command_transaction.sv]
// Top of the SD SPI command exchange testbench: clock, reset, requests and receiver stalls.
// Depends on sdspi_pkg, the block sd_spi_command_transaction and sd_spi_exchange_checker.
`timescale 1ns / 100ps

module tb_sd_spi_command_transaction;
  import sdspi_pkg::*;

  localparam int RANDOM_ITEMS   = 430;
  localparam int HOLD_CYCLES    = 60;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 20;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic        in_opcode;
  logic [5:0]  in_command_index;
  logic [31:0] in_argument;
  logic [2:0]  in_response_length;
  logic [7:0]  in_rx_byte;
  logic        out_valid;
  logic        out_ready;
  logic        out_kind;
  logic [7:0]  out_byte_value;
  logic [2:0]  out_byte_position;
  logic        out_last;
  logic        out_fault;

  int chk_errors;
  int chk_pending;
  int send_idle_pct;
  int recv_idle_pct;
  int requests_sent;
  int hold_req_count;
  int hold_served;
  int quiet_cycles;

  sd_spi_command_transaction dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_opcode          (in_opcode),
    .in_command_index   (in_command_index),
    .in_argument        (in_argument),
    .in_response_length (in_response_length),
    .in_rx_byte         (in_rx_byte),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_kind           (out_kind),
    .out_byte_value     (out_byte_value),
    .out_byte_position  (out_byte_position),
    .out_last           (out_last),
    .out_fault          (out_fault)
  );

  sd_spi_exchange_checker checker_i (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_opcode          (in_opcode),
    .in_command_index   (in_command_index),
    .in_argument        (in_argument),
    .in_response_length (in_response_length),
    .in_rx_byte         (in_rx_byte),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_kind           (out_kind),
    .out_byte_value     (out_byte_value),
    .out_byte_position  (out_byte_position),
    .out_last           (out_last),
    .out_fault          (out_fault),
    .error_count        (chk_errors),
    .pending            (chk_pending)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Offer one request, idling first at random, and hold it until taken
  task automatic send_request(input op_t op, input logic [5:0] cmd, input logic [31:0] arg,
                              input logic [2:0] rlen, input logic [7:0] rx);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid           <= 1'b1;
    in_opcode          <= op;
    in_command_index   <= cmd;
    in_argument        <= arg;
    in_response_length <= rlen;
    in_rx_byte         <= rx;
    @(posedge clk);
    while (!in_ready) begin
      @(posedge clk);
    end
    requests_sent++;
  endtask

  // Start a command; the card byte field carries noise
  task automatic send_start(input logic [5:0] cmd, input logic [31:0] arg,
                            input logic [2:0] rlen);
    send_request(OP_START, cmd, arg, rlen, 8'($urandom));
  endtask

  // Deliver one card byte; command fields carry noise
  task automatic send_rx(input logic [7:0] rx);
    send_request(OP_RX, 6'($urandom), $urandom, 3'($urandom), rx);
  endtask

  // One command exchange with random content, sometimes broken or cut short
  task automatic run_exchange();
    int          pick;
    logic [2:0]  rlen;
    int          resp_bytes;
    int          fills;
    logic [7:0]  rx;
    pick = $urandom_range(99);
    if (pick < 8) begin
      // Stray card byte, sent with no start of its own
      send_rx(8'($urandom));
    end else begin
      if ($urandom_range(99) < 75) begin
        rlen = ($urandom_range(1) == 0) ? 3'd1 : 3'd5;
      end else begin
        rlen = 3'($urandom_range(7));
      end
      resp_bytes = (rlen == 3'd0) ? 1 : ((rlen > MAX_RESPONSE_BYTES) ? 5 : int'(rlen));
      send_start(6'($urandom_range(63)), $urandom, rlen);
      fills = ($urandom_range(99) < 50) ? 0 : $urandom_range(4);
      for (int i = 0; i < fills; i++) begin
        send_rx(FILL_BYTE);
      end
      // Cut short now and then, leaving the block busy
      if ($urandom_range(99) < 5) begin
        resp_bytes = $urandom_range(resp_bytes - 1);
      end
      for (int i = 0; i < resp_bytes; i++) begin
        if ($urandom_range(99) < 6) begin
          send_start(6'($urandom_range(63)), $urandom, 3'($urandom));
        end
        rx = 8'($urandom);
        if (i == 0 && rx == FILL_BYTE) begin
          rx = 8'($urandom_range(254));
        end
        send_rx(rx);
      end
    end
  endtask

  // Receiver: random stalls, plus long hold-offs on request
  initial begin
    out_ready   = 1'b0;
    hold_served = 0;
    @(posedge clk);
    forever begin
      if (hold_req_count != hold_served) begin
        hold_served = hold_req_count;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
        @(posedge clk);
      end
    end
  end

  // Watchdog: end the run when nothing moves for too long
  initial begin
    quiet_cycles = 0;
    @(posedge rst_n);
    while (quiet_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
    end
    $display("%0t: watchdog expired, no handshake for %0d cycles", $time, WATCHDOG_LIMIT);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Stimulus and verdict
  initial begin
    rst_n              = 1'b0;
    in_valid           = 1'b0;
    in_opcode          = OP_START;
    in_command_index   = '0;
    in_argument        = '0;
    in_response_length = '0;
    in_rx_byte         = '0;
    send_idle_pct      = 36;
    recv_idle_pct      = 80;
    requests_sent      = 0;
    hold_req_count     = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: wrong phases, fill bytes, extremes and length clamping
    send_rx(8'h00);
    send_start(6'd0, 32'h0000_0000, 3'd1);
    send_rx(FILL_BYTE);
    send_start(6'd63, 32'hFFFF_FFFF, 3'd5);
    send_rx(8'h00);
    send_start(6'd63, 32'hFFFF_FFFF, 3'd5);
    send_rx(8'hFE);
    send_rx(FILL_BYTE);
    send_rx(8'h01);
    send_rx(8'hAA);
    send_rx(8'h55);
    send_start(6'd8, 32'h0000_01AA, 3'd0);
    send_rx(8'h01);
    send_start(6'd58, 32'h0000_0000, 3'd7);
    send_rx(8'h00);
    send_rx(8'h80);
    send_rx(FILL_BYTE);
    send_rx(8'h7F);
    send_rx(8'h12);
    send_start(6'd17, 32'h1234_5678, 3'd6);
    send_rx(8'h00);
    send_rx(8'h11);
    send_rx(8'h22);
    send_rx(8'h33);
    send_rx(8'h44);

    // Random exchanges over three idling regimes
    hold_req_count <= hold_req_count + 1;
    while (requests_sent < RANDOM_ITEMS) begin
      if (requests_sent >= 2 * RANDOM_ITEMS / 3 && send_idle_pct != 0) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_req_count <= hold_req_count + 1;
      end else if (requests_sent >= RANDOM_ITEMS / 3 && requests_sent < 2 * RANDOM_ITEMS / 3) begin
        send_idle_pct = 80;
        recv_idle_pct = 36;
      end
      run_exchange();
    end
    in_valid <= 1'b0;

    // Let every predicted byte arrive, then watch for strays
    @(posedge clk);
    @(posedge clk);
    while (chk_pending != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (chk_errors == 0 && chk_pending == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

[sd_spi_command_transaction.f]
design/sdspi_pkg.sv
design/sdspi_front.sv
design/sdspi_queue.sv
design/sdspi_back.sv
design/sd_spi_command_transaction.sv
verif/sd_spi_exchange_checker.sv
verif/tb_sd_spi_command_transaction.sv
